FILE: src/spli_pkg.sv
package spli_pkg;

    // List geometry.
    localparam int CAPACITY  = 64;
    localparam int PRIO_BITS = 6;
    localparam int ADDR_BITS = $clog2(CAPACITY);
    localparam int CNT_BITS  = $clog2(CAPACITY + 1);

    // Field widths of the stream payloads.
    localparam int INDEX_BITS  = 6;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 7;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 16;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HEAD,
        S_TAIL,
        S_WALK,
        S_PLACE,
        S_READ,
        S_DONE
    } state_t;

endpackage

FILE: src/sorted_priority_list_insert_top.sv
// Sorted priority list held in a 64-entry synchronous RAM in descending order.
// Each input transfer is an insert (tuser 0) or a read of the entry at an index
// (tuser 1), and each gives exactly one output transfer with a status, the read
// priority and the entry count after the item. One item is processed at a time.
// A read of an index past the end skips the RAM read and its read state.
// An insert into a non-empty list reads the head and then the tail, and every
// entry that moves one place toward the tail adds a walk step; the walk starts
// at the tail and goes through the single RAM read port one entry per cycle, so
// a value that lands at the head of the list passes every entry and then a place
// step. An insert into an empty or a full list goes straight to its result.
// A new item is taken while the previous result still waits on the output.
module sorted_priority_list_insert_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: priority_req[5:0], read_index[11:6], zero fill.
    input  logic [spli_pkg::IN_DATA_W-1:0]      s_tdata,
    // Fields from bit 0: opcode[0].
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: read_priority[5:0], entry_count[12:6], zero fill.
    output logic [spli_pkg::OUT_DATA_W-1:0]     m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [spli_pkg::STATUS_BITS-1:0]    m_tuser
);

    localparam int PB = spli_pkg::PRIO_BITS;
    localparam int AB = spli_pkg::ADDR_BITS;
    localparam int CB = spli_pkg::CNT_BITS;

    spli_pkg::state_t  state_reg, state_next;
    logic [CB-1:0]     count_reg, count_next;
    logic [CB-1:0]     k_reg, k_next;
    logic              mode_reg, mode_next;
    logic [PB-1:0]     prio_reg, prio_next;
    logic [PB-1:0]     head_reg, head_next;
    spli_pkg::status_t res_status_reg, res_status_next;
    logic [PB-1:0]     res_prio_reg, res_prio_next;

    logic                      out_valid_reg, out_valid_next;
    spli_pkg::status_t         out_status_reg, out_status_next;
    logic [PB-1:0]             out_prio_reg, out_prio_next;
    logic [CB-1:0]             out_count_reg, out_count_next;

    // Entry RAM with one write port and one registered read port.
    logic [PB-1:0] mem [spli_pkg::CAPACITY];
    logic [PB-1:0] rdata_reg;
    logic [AB-1:0] rd_addr;
    logic [AB-1:0] wr_addr;
    logic [PB-1:0] wr_data;
    logic          wr_en;

    // Walk helpers.
    logic [PB:0]   prio_sum;
    logic [PB-1:0] prio_mid;
    logic          head_mode;
    logic          shift_entry;
    logic          accept;
    logic          in_range;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == spli_pkg::S_IDLE);
    assign in_range = ({1'b0, s_tdata[2*spli_pkg::INDEX_BITS-1:spli_pkg::INDEX_BITS]}
                       < count_reg);

    assign prio_sum  = {1'b0, head_reg} + {1'b0, rdata_reg};
    assign prio_mid  = prio_sum[PB:1];
    assign head_mode = (state_reg == spli_pkg::S_TAIL) ? (prio_reg >= prio_mid) : mode_reg;
    // A head search lets equal entries stay behind the new value.
    assign shift_entry = head_mode ? (rdata_reg <= prio_reg) : (rdata_reg < prio_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    // Control and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spli_pkg::S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        mode_reg       <= mode_next;
        prio_reg       <= prio_next;
        head_reg       <= head_next;
        res_status_reg <= res_status_next;
        res_prio_reg   <= res_prio_next;
        out_status_reg <= out_status_next;
        out_prio_reg   <= out_prio_next;
        out_count_reg  <= out_count_next;
    end

    // Sequencer: index reads, and for inserts head and tail reads, then a tail-first shifting walk.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        mode_next       = mode_reg;
        prio_next       = prio_reg;
        head_next       = head_reg;
        res_status_next = res_status_reg;
        res_prio_next   = res_prio_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_prio_next   = out_prio_reg;
        out_count_next  = out_count_reg;
        rd_addr         = '0;
        wr_addr         = '0;
        wr_data         = prio_reg;
        wr_en           = 1'b0;

        case (state_reg)
            spli_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    prio_next       = s_tdata[PB-1:0];
                    res_prio_next   = '0;
                    res_status_next = spli_pkg::STATUS_OK;
                    if (s_tuser == spli_pkg::OP_READ)
                    begin
                        rd_addr = s_tdata[spli_pkg::INDEX_BITS +: AB];
                        if (in_range)
                        begin
                            state_next = spli_pkg::S_READ;
                        end
                        else
                        begin
                            res_status_next = spli_pkg::STATUS_RANGE;
                            state_next      = spli_pkg::S_DONE;
                        end
                    end
                    else if (count_reg == CB'(spli_pkg::CAPACITY))
                    begin
                        res_status_next = spli_pkg::STATUS_FULL;
                        state_next      = spli_pkg::S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = s_tdata[PB-1:0];
                        count_next = CB'(1);
                        state_next = spli_pkg::S_DONE;
                    end
                    else
                    begin
                        rd_addr    = '0;
                        state_next = spli_pkg::S_HEAD;
                    end
                end
            end

            spli_pkg::S_HEAD:
            begin
                head_next  = rdata_reg;
                rd_addr    = AB'(count_reg - CB'(1));
                k_next     = count_reg;
                state_next = spli_pkg::S_TAIL;
            end

            spli_pkg::S_TAIL, spli_pkg::S_WALK:
            begin
                mode_next = head_mode;
                wr_en     = 1'b1;
                wr_addr   = k_reg[AB-1:0];
                if (shift_entry)
                begin
                    wr_data = rdata_reg;
                    k_next  = k_reg - CB'(1);
                    if (k_reg == CB'(1))
                    begin
                        state_next = spli_pkg::S_PLACE;
                    end
                    else
                    begin
                        rd_addr    = AB'(k_reg - CB'(2));
                        state_next = spli_pkg::S_WALK;
                    end
                end
                else
                begin
                    wr_data    = prio_reg;
                    count_next = count_reg + CB'(1);
                    state_next = spli_pkg::S_DONE;
                end
            end

            spli_pkg::S_PLACE:
            begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = prio_reg;
                count_next = count_reg + CB'(1);
                state_next = spli_pkg::S_DONE;
            end

            spli_pkg::S_READ:
            begin
                res_prio_next = rdata_reg;
                state_next    = spli_pkg::S_DONE;
            end

            spli_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_prio_next   = res_prio_reg;
                    out_count_next  = count_reg;
                    state_next      = spli_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = spli_pkg::S_IDLE;
            end
        endcase
    end

    // Output stream.
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(spli_pkg::OUT_DATA_W - PB - spli_pkg::COUNT_BITS){1'b0}},
                       spli_pkg::COUNT_BITS'(out_count_reg), out_prio_reg};

endmodule

FILE: dv/sorted_priority_list_insert_top_test.sv
module sorted_priority_list_insert_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1800;
    localparam int DIR_ROWS     = 20;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 100;
    localparam int PB           = spli_pkg::PRIO_BITS;
    localparam int IB           = spli_pkg::INDEX_BITS;
    localparam int CNB          = spli_pkg::COUNT_BITS;

    // One result as the block reports it.
    typedef struct packed {
        spli_pkg::status_t   status;
        logic [PB-1:0]       read_priority;
        logic [CNB-1:0]      entry_count;
    } list_result_t;

    // One row of the directed table; known marks a result typed in by hand.
    typedef struct packed {
        spli_pkg::opcode_t   op;
        logic [PB-1:0]       prio;
        logic [IB-1:0]       idx;
        bit                  known;
        list_result_t        result;
    } dir_row_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [spli_pkg::IN_DATA_W-1:0]      s_tdata = '0;
    logic                                s_tuser = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [spli_pkg::OUT_DATA_W-1:0]     m_tdata;
    logic [spli_pkg::STATUS_BITS-1:0]    m_tuser;

    // Predicted list contents, kept in descending order.
    logic [PB-1:0]              list_prio [spli_pkg::CAPACITY];
    int                         list_len = 0;

    list_result_t               expected_results [$];
    int                         error_count = 0;
    int                         results_seen = 0;
    int                         inserts_done = 0;
    int                         inserts_full = 0;
    int                         reads_done = 0;
    int                         reads_range = 0;

    // Hand-written opening sequence; rows without a typed result use the predictor.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{spli_pkg::OP_READ,   6'd0,  6'd0,  1'b1, '{spli_pkg::STATUS_RANGE, 6'd0,  7'd0}},
        '{spli_pkg::OP_READ,   6'd0,  6'd63, 1'b1, '{spli_pkg::STATUS_RANGE, 6'd0,  7'd0}},
        '{spli_pkg::OP_INSERT, 6'd63, 6'd0,  1'b1, '{spli_pkg::STATUS_OK,    6'd0,  7'd1}},
        '{spli_pkg::OP_INSERT, 6'd0,  6'd63, 1'b1, '{spli_pkg::STATUS_OK,    6'd0,  7'd2}},
        '{spli_pkg::OP_READ,   6'd0,  6'd0,  1'b1, '{spli_pkg::STATUS_OK,    6'd63, 7'd2}},
        '{spli_pkg::OP_READ,   6'd63, 6'd1,  1'b1, '{spli_pkg::STATUS_OK,    6'd0,  7'd2}},
        '{spli_pkg::OP_READ,   6'd0,  6'd2,  1'b1, '{spli_pkg::STATUS_RANGE, 6'd0,  7'd2}},
        '{spli_pkg::OP_INSERT, 6'd31, 6'd0,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_INSERT, 6'd30, 6'd0,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_INSERT, 6'd63, 6'd0,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_INSERT, 6'd0,  6'd0,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_INSERT, 6'd31, 6'd0,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_INSERT, 6'd42, 6'd0,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_INSERT, 6'd1,  6'd0,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_INSERT, 6'd62, 6'd63, 1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_READ,   6'd0,  6'd0,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_READ,   6'd0,  6'd5,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_READ,   6'd0,  6'd10, 1'b1, '{spli_pkg::STATUS_RANGE, 6'd0,  7'd10}},
        '{spli_pkg::OP_READ,   6'd0,  6'd9,  1'b0, '{spli_pkg::STATUS_OK,    6'd0,  7'd0}},
        '{spli_pkg::OP_READ,   6'd0,  6'd63, 1'b1, '{spli_pkg::STATUS_RANGE, 6'd0,  7'd10}}
    };

    sorted_priority_list_insert_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        // Fields from bit 0: priority_req[5:0], read_index[11:6], zero fill.
        .s_tdata  (s_tdata),
        // Fields from bit 0: opcode[0].
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        // Fields from bit 0: read_priority[5:0], entry_count[12:6], zero fill.
        .m_tdata  (m_tdata),
        // Fields from bit 0: status[1:0].
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Apply one item to the predicted list and return the result it gives.
    function automatic list_result_t list_apply(spli_pkg::opcode_t op, logic [PB-1:0] prio,
                                                logic [IB-1:0] idx);
        list_result_t r;
        int           pos;
        int           head;
        int           tail;
        r.status        = spli_pkg::STATUS_OK;
        r.read_priority = '0;
        if (op == spli_pkg::OP_INSERT)
        begin
            if (list_len >= spli_pkg::CAPACITY)
            begin
                r.status = spli_pkg::STATUS_FULL;
            end
            else if (list_len == 0)
            begin
                list_prio[0] = prio;
                list_len     = 1;
            end
            else
            begin
                // Search from the head for high values, from the tail for low ones.
                head = int'(list_prio[0]);
                tail = int'(list_prio[list_len-1]);
                if (int'(prio) >= (head + tail) / 2)
                begin
                    pos = 0;
                    while (pos < list_len && list_prio[pos] > prio)
                        pos++;
                end
                else
                begin
                    pos = list_len;
                    while (pos > 0 && list_prio[pos-1] < prio)
                        pos--;
                end
                for (int k = list_len; k > pos; k--)
                    list_prio[k] = list_prio[k-1];
                list_prio[pos] = prio;
                list_len++;
            end
        end
        else if (int'(idx) < list_len)
        begin
            r.read_priority = list_prio[idx];
        end
        else
        begin
            r.status = spli_pkg::STATUS_RANGE;
        end
        r.entry_count = list_len[CNB-1:0];
        return r;
    endfunction

    // Offer one item after a gap and queue its expected result once it is taken.
    task automatic send_item(spli_pkg::opcode_t op, logic [PB-1:0] prio,
                             logic [IB-1:0] idx, int gap, bit known,
                             list_result_t typed_result);
        list_result_t r;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(spli_pkg::IN_DATA_W-IB-PB){1'b0}}, idx, prio};
        do
            @(posedge clk);
        while (!s_tready);
        r = list_apply(op, prio, idx);
        // Tally the kinds of transfers sent for the summary.
        if (op == spli_pkg::OP_INSERT)
        begin
            if (r.status == spli_pkg::STATUS_FULL)
                inserts_full++;
            else
                inserts_done++;
        end
        else if (r.status == spli_pkg::STATUS_RANGE)
            reads_range++;
        else
            reads_done++;
        expected_results.push_back(known ? typed_result : r);
    endtask

    // Sender gap, with stretches of back-to-back transfers.
    function automatic int send_gap(int n);
        return ((n / 128) % 4 == 3) ? 0 : $urandom_range(0, 15);
    endfunction

    // Stimulus: reset, directed table, then random items.
    initial
    begin
        spli_pkg::opcode_t    op;
        logic [PB-1:0]        prio;
        logic [IB-1:0]        idx;
        int                   pick;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].op, dir_rows[i].prio, dir_rows[i].idx, send_gap(i),
                      dir_rows[i].known, dir_rows[i].result);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            op   = ($urandom_range(0, 5) == 0) ? spli_pkg::OP_INSERT : spli_pkg::OP_READ;
            prio = PB'($urandom_range(0, 63));
            idx  = IB'($urandom_range(0, 63));
            pick = int'($urandom_range(0, 7));
            // Steer priorities toward the ends, equals and the search boundary.
            if (pick == 0)
                prio = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            else if (list_len > 0 && pick == 1)
                prio = list_prio[0];
            else if (list_len > 0 && pick == 2)
                prio = list_prio[list_len-1];
            else if (list_len > 0 && pick == 3)
                prio = PB'((int'(list_prio[0]) + int'(list_prio[list_len-1])) / 2
                           - int'($urandom_range(0, 1)));
            // Read near the current end of the list half the time.
            if ($urandom_range(0, 1) && list_len > 0 && list_len < spli_pkg::CAPACITY)
                idx = IB'(list_len - 1 + int'($urandom_range(0, 2)));
            send_item(op, prio, idx, send_gap(i + DIR_ROWS), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d inserts, %0d rejected as full, %0d reads, %0d past the end.",
                 inserts_done, inserts_full, reads_done, reads_range);
        $display("Final list length %0d after %0d results.", list_len, results_seen);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Receiver: random stalls, bursts, and one long hold-off to back up the input.
    initial
    begin
        int  gap;
        bit  held;
        held = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER)
            begin
                gap  = HOLD_CYCLES;
                held = 1'b1;
            end
            else
            begin
                gap = ((results_seen / 100) % 4 == 2) ? 0 : $urandom_range(0, 15);
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    // Compare each output transfer with the oldest expected result.
    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: status %0d, read_priority %0d, entry_count %0d",
                       m_tuser, m_tdata[5:0], m_tdata[12:6]);
                error_count++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (m_tuser != exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tuser);
                    error_count++;
                end
                if (m_tdata[5:0] != exp_r.read_priority)
                begin
                    $error("read_priority: expected %0d, got %0d",
                           exp_r.read_priority, m_tdata[5:0]);
                    error_count++;
                end
                if (m_tdata[12:6] != exp_r.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_r.entry_count, m_tdata[12:6]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
src/spli_pkg.sv
src/sorted_priority_list_insert_top.sv
dv/sorted_priority_list_insert_top_test.sv
